>>> src/bldc32_pkg.sv
// shared constants, codes and the byte-wise crc-32 update for the log deframer
package bldc32_pkg;

	// parse phases
	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_CRC     = 2'd3;

	// result event codes
	localparam logic [2:0] EV_PAYLOAD     = 3'd0;
	localparam logic [2:0] EV_FRAME_GOOD  = 3'd1;
	localparam logic [2:0] EV_CRC_BAD     = 3'd2;
	localparam logic [2:0] EV_HDR_LEN_BAD = 3'd3;
	localparam logic [2:0] EV_ZERO_LEN    = 3'd4;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_THIRD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HDR_LEN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_ENABLE  = 3'd4;
	localparam int CFG_DATA_W = 8;

	// configuration reset values
	localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h44;
	localparam logic [7:0] SYNC_THIRD_RST  = 8'h12;
	localparam logic [7:0] HDR_LEN_RST     = 8'd28;
	localparam logic       CRC_ENABLE_RST  = 1'b1;

	// header layout
	localparam logic [4:0] HDR_LAST_POS = 5'd27;
	localparam logic [4:0] POS_HDR_LEN  = 5'd3;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;

	// reflected crc-32 update by one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] t;
		t = {24'd0, crc[7:0] ^ b};
		for (int k = 0; k < 8; k++) begin
			t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
		end
		return {8'd0, crc[31:8]} ^ t;
	endfunction

endpackage

>>> src/binary_log_deframer_crc32_core.sv
// binary log deframer: sync hunt, header capture, payload pass-through, crc-32 verdict
// a byte accepted into the input register is processed from there, and any result it
// gives is written to the result register; throughput is one byte per cycle while the
// result side does not stall, as the crc byte update and parse logic sit between registers.
// reset (arst_n low, asynchronous) returns to sync hunt, clears the captured header
// fields and crc, and loads the sync, header length and crc enable defaults.
module binary_log_deframer_crc32_core (
	input  logic        clk,
	input  logic        arst_n,
	// input byte channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic [7:0]  payload_byte,
	output logic [15:0] payload_offset,
	output logic [15:0] message_id,
	output logic [15:0] message_length,
	output logic [15:0] time_week,
	output logic [31:0] time_milliseconds,
	output logic [31:0] receiver_status_word,
	output logic [31:0] received_crc,
	// configuration write port
	input  logic        cfg_we,
	input  logic [bldc32_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bldc32_pkg::CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [7:0] sync_first_q, sync_second_q, sync_third_q, hdr_len_q;
	logic       crc_en_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parser state
	logic [1:0]  phase_q, phase_n;
	logic [4:0]  pos_q, pos_n;
	logic [15:0] cnt_q, cnt_n;
	logic [15:0] id_q, id_n, len_q, len_n, week_q, week_n;
	logic [31:0] ms_q, ms_n, status_q, status_n, crc_q, crc_n, cap_q, cap_n;

	// result register
	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [7:0]  pbyte_q;
	logic [15:0] poff_q;

	logic        out_free, proc;
	logic        res_vld;
	logic [2:0]  res_kind;
	logic [7:0]  res_pbyte;
	logic [15:0] res_poff;
	logic [31:0] crc_upd;
	logic [7:0]  sync_want;
	logic [15:0] cnt_inc;

	assign out_free = !out_valid_q || !out_stall;
	assign proc     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= bldc32_pkg::SYNC_FIRST_RST;
			sync_second_q <= bldc32_pkg::SYNC_SECOND_RST;
			sync_third_q  <= bldc32_pkg::SYNC_THIRD_RST;
			hdr_len_q     <= bldc32_pkg::HDR_LEN_RST;
			crc_en_q      <= bldc32_pkg::CRC_ENABLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bldc32_pkg::REG_SYNC_FIRST:  sync_first_q  <= cfg_data[7:0];
				bldc32_pkg::REG_SYNC_SECOND: sync_second_q <= cfg_data[7:0];
				bldc32_pkg::REG_SYNC_THIRD:  sync_third_q  <= cfg_data[7:0];
				bldc32_pkg::REG_HDR_LEN:     hdr_len_q     <= cfg_data[7:0];
				bldc32_pkg::REG_CRC_ENABLE:  crc_en_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// next-state and result for the registered byte
	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		cnt_n     = cnt_q;
		id_n      = id_q;
		len_n     = len_q;
		week_n    = week_q;
		ms_n      = ms_q;
		status_n  = status_q;
		crc_n     = crc_q;
		cap_n     = cap_q;
		res_vld   = 1'b0;
		res_kind  = bldc32_pkg::EV_PAYLOAD;
		res_pbyte = 8'd0;
		res_poff  = 16'd0;
		crc_upd   = bldc32_pkg::crc_byte(crc_q, byte_s1);
		cnt_inc   = cnt_q + 16'd1;
		sync_want = (pos_q == 5'd0) ? sync_first_q :
			(pos_q == 5'd1) ? sync_second_q : sync_third_q;

		unique case (phase_q)
			bldc32_pkg::PH_HUNT: begin
				if (byte_s1 != sync_want) begin
					pos_n = 5'd0;
					cnt_n = 16'd0;
				end else begin
					if (pos_q == 5'd0) begin
						// new frame: clear the captured fields
						id_n     = 16'd0;
						len_n    = 16'd0;
						week_n   = 16'd0;
						ms_n     = 32'd0;
						status_n = 32'd0;
						cap_n    = 32'd0;
						crc_n    = bldc32_pkg::crc_byte(32'd0, byte_s1);
					end else begin
						crc_n = crc_upd;
					end
					pos_n = pos_q + 5'd1;
					if (pos_q >= 5'd2) begin
						phase_n = bldc32_pkg::PH_HEADER;
						pos_n   = bldc32_pkg::POS_HDR_LEN;
					end
				end
			end

			bldc32_pkg::PH_HEADER: begin
				if (pos_q == bldc32_pkg::POS_HDR_LEN && byte_s1 != hdr_len_q) begin
					phase_n  = bldc32_pkg::PH_HUNT;
					pos_n    = 5'd0;
					cnt_n    = 16'd0;
					res_vld  = 1'b1;
					res_kind = bldc32_pkg::EV_HDR_LEN_BAD;
				end else begin
					crc_n = crc_upd;
					// little-endian field capture
					case (pos_q)
						5'd4:  id_n[7:0]       = id_q[7:0] | byte_s1;
						5'd5:  id_n[15:8]      = id_q[15:8] | byte_s1;
						5'd8:  len_n[7:0]      = len_q[7:0] | byte_s1;
						5'd9:  len_n[15:8]     = len_q[15:8] | byte_s1;
						5'd14: week_n[7:0]     = week_q[7:0] | byte_s1;
						5'd15: week_n[15:8]    = week_q[15:8] | byte_s1;
						5'd16: ms_n[7:0]       = ms_q[7:0] | byte_s1;
						5'd17: ms_n[15:8]      = ms_q[15:8] | byte_s1;
						5'd18: ms_n[23:16]     = ms_q[23:16] | byte_s1;
						5'd19: ms_n[31:24]     = ms_q[31:24] | byte_s1;
						5'd20: status_n[7:0]   = status_q[7:0] | byte_s1;
						5'd21: status_n[15:8]  = status_q[15:8] | byte_s1;
						5'd22: status_n[23:16] = status_q[23:16] | byte_s1;
						5'd23: status_n[31:24] = status_q[31:24] | byte_s1;
						default: ;
					endcase
					if (pos_q == 5'd9 && len_n == 16'd0) begin
						phase_n  = bldc32_pkg::PH_HUNT;
						pos_n    = 5'd0;
						cnt_n    = 16'd0;
						res_vld  = 1'b1;
						res_kind = bldc32_pkg::EV_ZERO_LEN;
					end else if (pos_q >= bldc32_pkg::HDR_LAST_POS) begin
						phase_n = bldc32_pkg::PH_PAYLOAD;
						pos_n   = 5'd0;
						cnt_n   = 16'd0;
					end else begin
						pos_n = pos_q + 5'd1;
					end
				end
			end

			bldc32_pkg::PH_PAYLOAD: begin
				crc_n     = crc_upd;
				res_vld   = 1'b1;
				res_kind  = bldc32_pkg::EV_PAYLOAD;
				res_pbyte = byte_s1;
				res_poff  = cnt_q;
				if (cnt_inc == len_q) begin
					phase_n = bldc32_pkg::PH_CRC;
					cnt_n   = 16'd0;
				end else begin
					cnt_n = cnt_inc;
				end
			end

			bldc32_pkg::PH_CRC: begin
				case (cnt_q[1:0])
					2'd0: cap_n[7:0]   = cap_q[7:0] | byte_s1;
					2'd1: cap_n[15:8]  = cap_q[15:8] | byte_s1;
					2'd2: cap_n[23:16] = cap_q[23:16] | byte_s1;
					default: cap_n[31:24] = cap_q[31:24] | byte_s1;
				endcase
				if (cnt_q[1:0] != 2'd3) begin
					cnt_n = {14'd0, cnt_q[1:0] + 2'd1};
				end else begin
					phase_n  = bldc32_pkg::PH_HUNT;
					pos_n    = 5'd0;
					cnt_n    = 16'd0;
					res_vld  = 1'b1;
					res_kind = (!crc_en_q || cap_n == crc_q) ?
						bldc32_pkg::EV_FRAME_GOOD : bldc32_pkg::EV_CRC_BAD;
				end
			end

			default: ;
		endcase
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= bldc32_pkg::PH_HUNT;
			pos_q    <= 5'd0;
			cnt_q    <= 16'd0;
			id_q     <= 16'd0;
			len_q    <= 16'd0;
			week_q   <= 16'd0;
			ms_q     <= 32'd0;
			status_q <= 32'd0;
			crc_q    <= 32'd0;
			cap_q    <= 32'd0;
		end else if (proc) begin
			phase_q  <= phase_n;
			pos_q    <= pos_n;
			cnt_q    <= cnt_n;
			id_q     <= id_n;
			len_q    <= len_n;
			week_q   <= week_n;
			ms_q     <= ms_n;
			status_q <= status_n;
			crc_q    <= crc_n;
			cap_q    <= cap_n;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && res_vld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, header fields as they stand after this byte
	logic [15:0] res_id_q, res_len_q, res_week_q;
	logic [31:0] res_ms_q, res_status_q, res_cap_q;

	always_ff @(posedge clk) begin
		if (proc && res_vld) begin
			kind_q       <= res_kind;
			pbyte_q      <= res_pbyte;
			poff_q       <= res_poff;
			res_id_q     <= id_n;
			res_len_q    <= len_n;
			res_week_q   <= week_n;
			res_ms_q     <= ms_n;
			res_status_q <= status_n;
			res_cap_q    <= cap_n;
		end
	end

	assign out_valid            = out_valid_q;
	assign event_kind           = kind_q;
	assign payload_byte         = pbyte_q;
	assign payload_offset       = poff_q;
	assign message_id           = res_id_q;
	assign message_length       = res_len_q;
	assign time_week            = res_week_q;
	assign time_milliseconds    = res_ms_q;
	assign receiver_status_word = res_status_q;
	assign received_crc         = res_cap_q;

endmodule

>>> dv/binary_log_deframer_crc32_core_tb.sv
// self-checking testbench for the binary log deframer with crc-32 verdict
module binary_log_deframer_crc32_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] REFLECTED_POLY = 32'hEDB88320;
	localparam int          HEADER_LAST    = 27;
	localparam int          DRAIN_CYCLES   = 8;
	localparam int          CYCLE_LIMIT    = 1000000;
	localparam int          MAX_REPORTS    = 100;

	// one result transfer, field for field
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  pbyte;
		logic [15:0] poff;
		logic [15:0] id;
		logic [15:0] len;
		logic [15:0] week;
		logic [31:0] msec;
		logic [31:0] status;
		logic [31:0] crc;
	} deframe_event_t;

	typedef enum {FR_GOOD, FR_BAD_CRC, FR_HDR_LEN, FR_ZERO_LEN} frame_kind_t;

	// deframer predictor plus queue of expected events
	class deframe_scoreboard;
		logic [7:0]  sync_val [3];
		logic [7:0]  hdr_len_req;
		logic        crc_on;
		logic [1:0]  phase;
		logic [4:0]  hpos;
		logic [15:0] count;
		logic [15:0] id_r, len_r, week_r;
		logic [31:0] msec_r, status_r, crc_run, crc_rx;
		deframe_event_t expected_events[$];
		int errors;
		int n_payload, n_good, n_crc_bad, n_hdr_bad, n_zero;

		function new();
			sync_val[0] = 8'hAA;
			sync_val[1] = 8'h44;
			sync_val[2] = 8'h12;
			hdr_len_req = 8'd28;
			crc_on = 1'b1;
			resync();
			id_r = '0;
			len_r = '0;
			week_r = '0;
			msec_r = '0;
			status_r = '0;
			crc_run = '0;
			crc_rx = '0;
			errors = 0;
			n_payload = 0;
			n_good = 0;
			n_crc_bad = 0;
			n_hdr_bad = 0;
			n_zero = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [7:0] val);
			case (idx)
				bldc32_pkg::REG_SYNC_FIRST:  sync_val[0] = val;
				bldc32_pkg::REG_SYNC_SECOND: sync_val[1] = val;
				bldc32_pkg::REG_SYNC_THIRD:  sync_val[2] = val;
				bldc32_pkg::REG_HDR_LEN:     hdr_len_req = val;
				bldc32_pkg::REG_CRC_ENABLE:  crc_on = val[0];
				default: ;
			endcase
		endfunction

		// bit-serial reflected crc-32, lsb of the byte first
		function logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
			logic [31:0] r;
			r = c;
			for (int i = 0; i < 8; i++) begin
				r = (r >> 1) ^ ((r[0] ^ b[i]) ? REFLECTED_POLY : 32'h0);
			end
			return r;
		endfunction

		function void resync();
			phase = bldc32_pkg::PH_HUNT;
			hpos = '0;
			count = '0;
		endfunction

		function void post(logic [2:0] kind, logic [7:0] pb, logic [15:0] po);
			deframe_event_t e;
			e.kind = kind;
			e.pbyte = pb;
			e.poff = po;
			e.id = id_r;
			e.len = len_r;
			e.week = week_r;
			e.msec = msec_r;
			e.status = status_r;
			e.crc = crc_rx;
			expected_events.push_back(e);
		endfunction

		// advance the parser by one accepted byte
		function void take_rx_byte(logic [7:0] b);
			logic [7:0] want;
			logic [4:0] p;
			logic [1:0] k;
			p = hpos;
			case (phase)
				bldc32_pkg::PH_HUNT: begin
					want = (p == 0) ? sync_val[0] : (p == 1) ? sync_val[1] : sync_val[2];
					if (b != want) begin
						// the failing byte is not tried again as a first sync byte
						resync();
					end else begin
						if (p == 0) begin
							crc_run = '0;
							id_r = '0;
							len_r = '0;
							week_r = '0;
							msec_r = '0;
							status_r = '0;
							crc_rx = '0;
						end
						crc_run = crc_next(crc_run, b);
						hpos = p + 5'd1;
						if (p >= 2) begin
							phase = bldc32_pkg::PH_HEADER;
							hpos = 5'd3;
						end
					end
				end
				bldc32_pkg::PH_HEADER: begin
					if (p == 3 && b != hdr_len_req) begin
						resync();
						post(bldc32_pkg::EV_HDR_LEN_BAD, '0, '0);
					end else begin
						crc_run = crc_next(crc_run, b);
						case (p)
							5'd4:  id_r[7:0] = b;
							5'd5:  id_r[15:8] = b;
							5'd8:  len_r[7:0] = b;
							5'd9:  len_r[15:8] = b;
							5'd14: week_r[7:0] = b;
							5'd15: week_r[15:8] = b;
							5'd16, 5'd17, 5'd18, 5'd19: msec_r[8*(p-16) +: 8] = b;
							5'd20, 5'd21, 5'd22, 5'd23: status_r[8*(p-20) +: 8] = b;
							default: ;
						endcase
						if (p == 9 && len_r == 0) begin
							resync();
							post(bldc32_pkg::EV_ZERO_LEN, '0, '0);
						end else if (p == HEADER_LAST) begin
							phase = bldc32_pkg::PH_PAYLOAD;
							hpos = '0;
							count = '0;
						end else begin
							hpos = p + 5'd1;
						end
					end
				end
				bldc32_pkg::PH_PAYLOAD: begin
					crc_run = crc_next(crc_run, b);
					post(bldc32_pkg::EV_PAYLOAD, b, count);
					count = count + 16'd1;
					if (count == len_r) begin
						phase = bldc32_pkg::PH_CRC;
						count = '0;
					end
				end
				default: begin
					// crc bytes arrive little-endian
					k = count[1:0];
					crc_rx[8*k +: 8] = b;
					if (k < 3) begin
						count = {14'd0, k} + 16'd1;
					end else begin
						resync();
						post((!crc_on || crc_rx == crc_run) ? bldc32_pkg::EV_FRAME_GOOD
							: bldc32_pkg::EV_CRC_BAD, '0, '0);
					end
				end
			endcase
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= MAX_REPORTS) $error("%s", msg);
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] seen);
			if (want !== seen)
				report($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, seen));
		endfunction

		function void check_event(deframe_event_t got);
			deframe_event_t exp;
			if (expected_events.size() == 0) begin
				report($sformatf("event_kind: expected none, got %0d", got.kind));
				return;
			end
			exp = expected_events.pop_front();
			compare("event_kind", 32'(exp.kind), 32'(got.kind));
			compare("payload_byte", 32'(exp.pbyte), 32'(got.pbyte));
			compare("payload_offset", 32'(exp.poff), 32'(got.poff));
			compare("message_id", 32'(exp.id), 32'(got.id));
			compare("message_length", 32'(exp.len), 32'(got.len));
			compare("time_week", 32'(exp.week), 32'(got.week));
			compare("time_milliseconds", exp.msec, got.msec);
			compare("receiver_status_word", exp.status, got.status);
			compare("received_crc", exp.crc, got.crc);
			case (exp.kind)
				bldc32_pkg::EV_PAYLOAD:     n_payload++;
				bldc32_pkg::EV_FRAME_GOOD:  n_good++;
				bldc32_pkg::EV_CRC_BAD:     n_crc_bad++;
				bldc32_pkg::EV_HDR_LEN_BAD: n_hdr_bad++;
				default:                    n_zero++;
			endcase
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  event_kind;
	logic [7:0]  payload_byte;
	logic [15:0] payload_offset;
	logic [15:0] message_id;
	logic [15:0] message_length;
	logic [15:0] time_week;
	logic [31:0] time_milliseconds;
	logic [31:0] receiver_status_word;
	logic [31:0] received_crc;
	logic        cfg_we;
	logic [bldc32_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bldc32_pkg::CFG_DATA_W-1:0] cfg_data;

	deframe_scoreboard sb = new();
	bit idle_on = 1'b1;
	int bytes_sent = 0;
	int junk_bytes = 0;
	int settings_used = 0;
	int cycles = 0;

	binary_log_deframer_crc32_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// result side: random stall runs, check every transfer
	initial begin : result_monitor
		deframe_event_t got;
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.kind = event_kind;
				got.pbyte = payload_byte;
				got.poff = payload_offset;
				got.id = message_id;
				got.len = message_length;
				got.week = time_week;
				got.msec = time_milliseconds;
				got.status = receiver_status_word;
				got.crc = received_crc;
				sb.check_event(got);
			end
			if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// one byte transfer on the input channel
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.take_rx_byte(b);
		bytes_sent++;
	endtask

	// a byte that cannot match any sync value
	function automatic logic [7:0] pick_filler();
		logic [7:0] f;
		do f = 8'($urandom_range(0, 255));
		while (f == sb.sync_val[0] || f == sb.sync_val[1] || f == sb.sync_val[2]);
		return f;
	endfunction

	// leading sync bytes, random bytes, then a byte that drops the hunt
	task automatic send_junk(input int n_sync, input int n_rand);
		for (int i = 0; i < n_sync; i++) send_byte(sb.sync_val[i]);
		for (int i = 0; i < n_rand; i++) send_byte(8'($urandom));
		send_byte(pick_filler());
		junk_bytes += n_sync + n_rand + 1;
	endtask

	// frame builder; fill < 0 gives random header and payload content
	task automatic send_frame(input frame_kind_t kind, input int plen, input int fill);
		logic [7:0]  hdr [28];
		logic [15:0] len16;
		logic [31:0] crc;
		logic [7:0]  b;
		int last;
		foreach (hdr[i]) hdr[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
		hdr[0] = sb.sync_val[0];
		hdr[1] = sb.sync_val[1];
		hdr[2] = sb.sync_val[2];
		hdr[3] = sb.hdr_len_req;
		if (kind == FR_HDR_LEN) hdr[3] = sb.hdr_len_req ^ 8'($urandom_range(1, 255));
		len16 = (kind == FR_ZERO_LEN) ? 16'd0 : 16'(plen);
		hdr[8] = len16[7:0];
		hdr[9] = len16[15:8];
		last = (kind == FR_HDR_LEN) ? 3 : (kind == FR_ZERO_LEN) ? 9 : HEADER_LAST;
		crc = '0;
		for (int i = 0; i <= last; i++) begin
			crc = sb.crc_next(crc, hdr[i]);
			send_byte(hdr[i]);
		end
		if (kind == FR_HDR_LEN || kind == FR_ZERO_LEN) return;
		for (int i = 0; i < plen; i++) begin
			b = (fill < 0) ? 8'($urandom) : 8'(fill);
			crc = sb.crc_next(crc, b);
			send_byte(b);
		end
		if (kind == FR_BAD_CRC) crc ^= 32'($urandom) | (32'h1 << $urandom_range(0, 31));
		for (int k = 0; k < 4; k++) send_byte(crc[8*k +: 8]);
	endtask

	// write all five registers on consecutive cycles
	task automatic load_config(input logic [7:0] s0, input logic [7:0] s1,
			input logic [7:0] s2, input logic [7:0] hl, input logic en);
		logic [7:0] vals [5];
		logic [2:0] idxs [5];
		vals = '{s0, s1, s2, hl, {7'($urandom), en}};
		idxs = '{bldc32_pkg::REG_SYNC_FIRST, bldc32_pkg::REG_SYNC_SECOND,
			bldc32_pkg::REG_SYNC_THIRD, bldc32_pkg::REG_HDR_LEN,
			bldc32_pkg::REG_CRC_ENABLE};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idxs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.write_reg(idxs[i], vals[i]);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// all expected events in, then let bytes with no result clear the pipe
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_len();
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 8);
		return $urandom_range(9, 40);
	endfunction

	// mostly whole frames with random content, some broken ones and noise
	task automatic random_phase(input int budget);
		int start, r;
		start = bytes_sent - junk_bytes;
		while (bytes_sent - junk_bytes - start < budget) begin
			r = $urandom_range(0, 99);
			if (r < 55) send_frame(FR_GOOD, pick_len(), -1);
			else if (r < 70) send_frame(FR_BAD_CRC, pick_len(), -1);
			else if (r < 78) send_frame(FR_HDR_LEN, 0, -1);
			else if (r < 86) send_frame(FR_ZERO_LEN, 0, -1);
			else if (r < 93) send_junk($urandom_range(1, 2), 0);
			else send_junk(0, $urandom_range(1, 8));
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		rx_byte <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset defaults: field extremes and each rejection
		send_frame(FR_GOOD, 1, 8'hFF);
		send_frame(FR_GOOD, 2, 8'h00);
		send_frame(FR_BAD_CRC, 3, -1);
		send_frame(FR_HDR_LEN, 0, -1);
		send_frame(FR_ZERO_LEN, 0, -1);
		// repeated first sync byte is not taken as a new start
		send_byte(sb.sync_val[0]);
		send_junk(3, 0);
		// sync lost at the second and at the third byte
		send_junk(1, 0);
		send_junk(2, 0);
		send_frame(FR_GOOD, 1, -1);
		wait_drained();
		// crc compare disabled: a corrupt frame still passes
		load_config(bldc32_pkg::SYNC_FIRST_RST, bldc32_pkg::SYNC_SECOND_RST,
			bldc32_pkg::SYNC_THIRD_RST, bldc32_pkg::HDR_LEN_RST, 1'b0);
		send_frame(FR_BAD_CRC, 2, -1);
		send_frame(FR_GOOD, 1, -1);
		wait_drained();

		// random phases across register settings
		load_config(bldc32_pkg::SYNC_FIRST_RST, bldc32_pkg::SYNC_SECOND_RST,
			bldc32_pkg::SYNC_THIRD_RST, bldc32_pkg::HDR_LEN_RST, 1'b1);
		random_phase(100);
		wait_drained();
		load_config(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		random_phase(100);
		wait_drained();
		idle_on = 1'b0;
		load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		random_phase(100);
		wait_drained();
		idle_on = 1'b1;
		load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
		random_phase(100);
		wait_drained();
		load_config(bldc32_pkg::SYNC_FIRST_RST, bldc32_pkg::SYNC_SECOND_RST,
			bldc32_pkg::SYNC_THIRD_RST, bldc32_pkg::HDR_LEN_RST, 1'b1);
		send_frame(FR_GOOD, 300, -1);
		random_phase(60);
		wait_drained();

		$display("run: %0d bytes in, %0d register settings, %0d payload bytes out",
			bytes_sent, settings_used, sb.n_payload);
		$display("verdicts: %0d good, %0d crc mismatch, %0d bad header length, %0d zero length",
			sb.n_good, sb.n_crc_bad, sb.n_hdr_bad, sb.n_zero);
		if (sb.errors == 0 && sb.expected_events.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
